@@ design/tbpg_pkg.sv @@
// Shared constants, codes and types for the token bucket packet gate.
`default_nettype none
package tbpg_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TOKEN_BITS  = 10;
    localparam int ID_W        = 32;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths on the ports
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int OCC_W       = 7;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 104;

    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ARRIVAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd4;

    localparam logic [TOKEN_BITS-1:0] DEPTH_RESET = TOKEN_BITS'(10);

    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [TOKEN_BITS-1:0] need;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } queue_ctrl_t;

endpackage
`default_nettype wire

@@ design/tbpg_queue.sv @@
// Packet queue: registered head entry plus a ring memory with a prefetched front.
`default_nettype none
module tbpg_queue (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire tbpg_pkg::queue_ctrl_t     ctrl,
    input  wire tbpg_pkg::entry_t          push_entry,
    output tbpg_pkg::head_t                head,
    output logic [tbpg_pkg::CNT_W-1:0]     count
);
    import tbpg_pkg::*;

    entry_t              mem [QUEUE_DEPTH];
    entry_t              front_reg;
    head_t               head_reg, head_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    mem_count;
    logic                mem_wr, mem_rd;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb begin
        // entries behind the head live in the memory
        mem_count = count_reg - CNT_W'(head_reg.valid);
        mem_wr    = !ctrl.flush && ctrl.push && head_reg.valid &&
                    !(ctrl.pop && mem_count == '0);
        mem_rd    = !ctrl.flush && ctrl.pop && head_reg.valid && (mem_count != '0);

        head_next = head_reg;
        priority if (ctrl.flush) begin
            head_next.valid = 1'b0;
        end else if (mem_rd) begin
            head_next.entry = front_reg;
        end else if (ctrl.pop) begin
            // empty queue with push and pop: the new packet passes straight through
            head_next.valid = head_reg.valid && ctrl.push;
            head_next.entry = push_entry;
        end else if (ctrl.push && !head_reg.valid) begin
            head_next.valid = 1'b1;
            head_next.entry = push_entry;
        end

        if (ctrl.flush) begin
            count_next  = '0;
            rd_ptr_next = '0;
            wr_ptr_next = '0;
        end else begin
            count_next  = count_reg + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);
            rd_ptr_next = mem_rd ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
            wr_ptr_next = mem_wr ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            count_reg  <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end else begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // front of the memory is read ahead, with bypass of a same-cycle write
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            mem[wr_ptr_reg] <= push_entry;
        end
        if (mem_wr && wr_ptr_reg == rd_ptr_next) begin
            front_reg <= push_entry;
        end else begin
            front_reg <= mem[rd_ptr_next];
        end
    end

    assign head  = head_reg;
    assign count = count_reg;

endmodule
`default_nettype wire

@@ design/token_bucket_packet_gate_unit.sv @@
// Top level of the token bucket packet gate: input stage, event logic, result register.
`default_nettype none
// Takes one event per clock (tick, packet arrival or flush) while the result side
// accepts, and gives one result per event: each event passes the input register, then
// the result register. The event logic is a single pass of compare, add and queue
// pointer update; the 64-entry packet queue keeps its head in flip-flops and reads the
// next entry ahead from its memory, so a release can be followed by another in the
// next event. The result register lets a new event in while a result waits. No
// clearing pass after reset. After a flush every event is refused until reset.
module token_bucket_packet_gate_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tbpg_pkg::TOKEN_BITS-1:0]   cfg_wr_data,   // bucket_depth
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tbpg_pkg::S_TDATA_W-1:0]    s_tdata,       // need_tokens[9:0]
    input  wire logic [tbpg_pkg::KIND_W-1:0]       s_tuser,       // kind[1:0]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // packet_id[31:0], token_dropped[32], released[33], released_id[65:34],
    // released_need[75:66], token_level[85:76], queue_count[92:86],
    // removed_count[99:93]
    output logic [tbpg_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic [tbpg_pkg::STATUS_W-1:0]          m_tuser        // packet_status[2:0]
);
    import tbpg_pkg::*;

    logic                    in_valid_reg;
    logic [KIND_W-1:0]       in_kind_reg;
    logic [TOKEN_BITS-1:0]   in_need_reg;
    logic                    advance;

    logic [TOKEN_BITS-1:0]   depth_reg;
    logic [TOKEN_BITS-1:0]   tokens_reg, tokens_next;
    logic [ID_W-1:0]         arrivals_reg, arrivals_next;
    logic                    halted_reg, halted_next;

    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]     m_tuser_reg, m_tuser_next;

    queue_ctrl_t             q_ctrl;
    entry_t                  q_new;
    entry_t                  eff_head;
    head_t                   q_head;
    logic [CNT_W-1:0]        q_count;

    logic [TOKEN_BITS-1:0]   tok1;
    logic                    tdrop, try_rel, rel, is_arrival;
    logic [STATUS_W-1:0]     status;
    logic [ID_W-1:0]         pid;
    logic [CNT_W-1:0]        occ_next, removed;

    tbpg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (q_ctrl),
        .push_entry (q_new),
        .head       (q_head),
        .count      (q_count)
    );

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        status        = ST_NONE;
        pid           = '0;
        tok1          = tokens_reg;
        tdrop         = 1'b0;
        try_rel       = 1'b0;
        is_arrival    = 1'b0;
        removed       = '0;
        halted_next   = halted_reg;
        arrivals_next = arrivals_reg;
        q_ctrl        = '0;
        q_new.id      = arrivals_reg + ID_W'(1);
        q_new.need    = in_need_reg;

        if (halted_reg) begin
            status = ST_REFUSED;
        end else begin
            unique case (in_kind_reg)
                KIND_TICK: begin
                    if (tokens_reg < depth_reg) begin
                        tok1 = tokens_reg + TOKEN_BITS'(1);
                    end else begin
                        tdrop = 1'b1;
                    end
                    try_rel = 1'b1;
                end
                KIND_ARRIVAL: begin
                    is_arrival    = 1'b1;
                    arrivals_next = q_new.id;
                    pid           = q_new.id;
                    try_rel       = 1'b1;
                    priority if (in_need_reg > depth_reg) begin
                        status = ST_TOO_BIG;
                    end else if (q_count >= CNT_W'(QUEUE_DEPTH)) begin
                        status = ST_FULL;
                    end else begin
                        status      = ST_QUEUED;
                        q_ctrl.push = 1'b1;
                    end
                end
                KIND_FLUSH: begin
                    removed      = q_count;
                    q_ctrl.flush = 1'b1;
                    halted_next  = 1'b1;
                end
                KIND_UNUSED: begin
                end
                default: begin
                end
            endcase
        end

        // the head after a possible push into an empty queue
        eff_head = q_head.valid ? q_head.entry : q_new;
        rel      = try_rel && (q_head.valid || q_ctrl.push) && (eff_head.need <= tok1);
        q_ctrl.pop = rel;

        tokens_next = rel ? (tok1 - eff_head.need) : tok1;
        occ_next    = q_ctrl.flush ? '0
                    : q_count + CNT_W'(q_ctrl.push) - CNT_W'(rel);

        if (!advance) begin
            q_ctrl = '0;
        end

        m_tuser_next = status;
        m_tdata_next = '0;
        m_tdata_next[31:0]  = pid;
        m_tdata_next[32]    = tdrop;
        m_tdata_next[33]    = rel;
        m_tdata_next[65:34] = rel ? eff_head.id : '0;
        m_tdata_next[75:66] = rel ? eff_head.need : '0;
        m_tdata_next[85:76] = tokens_next;
        m_tdata_next[92:86] = OCC_W'(occ_next);
        m_tdata_next[99:93] = OCC_W'(removed);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            depth_reg    <= DEPTH_RESET;
            tokens_reg   <= '0;
            arrivals_reg <= '0;
            halted_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                depth_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_tvalid_reg <= 1'b1;
                tokens_reg   <= tokens_next;
                arrivals_reg <= arrivals_next;
                halted_reg   <= halted_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser;
            in_need_reg <= s_tdata[TOKEN_BITS-1:0];
        end
        if (advance) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // head register occupied exactly when the queue holds something
    a_head_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        q_head.valid == (q_count != '0))
        else $error("queue head valid disagrees with count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg && (q_count == '0))
        else $error("halt released or queue refilled");

    a_arrival_id_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_arrival) |=> arrivals_reg == $past(arrivals_reg) + ID_W'(1))
        else $error("arrival id did not advance by one");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Testbench for the token bucket packet gate: directed and random events checked by a predictor.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tbpg_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [STATUS_W-1:0]   status;
        logic [ID_W-1:0]       pid;
        logic                  tdrop;
        logic                  rel;
        logic [ID_W-1:0]       rid;
        logic [TOKEN_BITS-1:0] rneed;
        logic [TOKEN_BITS-1:0] level;
        logic [OCC_W-1:0]      qcount;
        logic [OCC_W-1:0]      removed;
    } gate_result_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [TOKEN_BITS-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic [KIND_W-1:0]     s_tuser     = KIND_TICK;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // predicted state of the gate
    logic [TOKEN_BITS-1:0] depth_reg     = DEPTH_RESET;
    logic [TOKEN_BITS-1:0] bucket_level  = '0;
    logic [ID_W-1:0]       arrival_count = '0;
    logic [ID_W-1:0]       slot_id   [QUEUE_DEPTH];
    logic [TOKEN_BITS-1:0] slot_need [QUEUE_DEPTH];
    int                    rd_slot = 0;
    int                    wr_slot = 0;
    int                    waiting = 0;
    bit                    gate_halted = 1'b0;

    gate_result_t expected_results[$];
    int  fail_count = 0;
    bit  idle_on    = 1'b1;
    bit  hold_req   = 1'b0;
    int  hold_len   = 0;
    int  stall_left = 0;
    int  cycles     = 0;

    token_bucket_packet_gate_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic gate_result_t compute_gate_result(input logic [KIND_W-1:0] kind,
                                                         input logic [TOKEN_BITS-1:0] need);
        gate_result_t r;
        bit try_release;
        r = '{default: '0};
        r.status = ST_NONE;
        try_release = 1'b0;
        if (gate_halted) begin
            r.status = ST_REFUSED;
        end else begin
            case (kind)
                KIND_TICK: begin
                    if (bucket_level < depth_reg)
                        bucket_level = bucket_level + TOKEN_BITS'(1);
                    else
                        r.tdrop = 1'b1;
                    try_release = 1'b1;
                end
                KIND_ARRIVAL: begin
                    // dropped packets still use up an id
                    arrival_count = arrival_count + ID_W'(1);
                    r.pid = arrival_count;
                    if (need > depth_reg) begin
                        r.status = ST_TOO_BIG;
                    end else if (waiting >= QUEUE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        slot_id[wr_slot]   = arrival_count;
                        slot_need[wr_slot] = need;
                        wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
                        waiting++;
                        r.status = ST_QUEUED;
                    end
                    try_release = 1'b1;
                end
                KIND_FLUSH: begin
                    r.removed = OCC_W'(waiting);
                    waiting = 0;
                    rd_slot = 0;
                    wr_slot = 0;
                    gate_halted = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (try_release && waiting > 0 && slot_need[rd_slot] <= bucket_level) begin
            r.rel   = 1'b1;
            r.rid   = slot_id[rd_slot];
            r.rneed = slot_need[rd_slot];
            bucket_level = bucket_level - slot_need[rd_slot];
            rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
            waiting--;
        end
        r.level  = bucket_level;
        r.qcount = OCC_W'(waiting);
        return r;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // result side: check every transfer, stall in bursts or on a hold request
    initial begin
        gate_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("packet_status", want.status, m_tuser);
                    check_field("packet_id",     want.pid,    m_tdata[31:0]);
                    check_field("token_dropped", want.tdrop,  m_tdata[32]);
                    check_field("released",      want.rel,    m_tdata[33]);
                    check_field("released_id",   want.rid,    m_tdata[65:34]);
                    check_field("released_need", want.rneed,  m_tdata[75:66]);
                    check_field("token_level",   want.level,  m_tdata[85:76]);
                    check_field("queue_count",   want.qcount, m_tdata[92:86]);
                    check_field("removed_count", want.removed, m_tdata[99:93]);
                end
            end
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = hold_len;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 15);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // valid is left high after a transfer; the next call either re-drives or drops it
    task automatic send_event(input logic [KIND_W-1:0] kind,
                              input logic [TOKEN_BITS-1:0] need);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'(need);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(compute_gate_result(kind, need));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_depth(input logic [TOKEN_BITS-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        depth_reg = value;
    endtask

    // mostly small needs so the head keeps moving; a few too big for the bucket
    task automatic send_random_event();
        int pick;
        int cap;
        logic [TOKEN_BITS-1:0] need;
        pick = $urandom_range(0, 99);
        cap  = (depth_reg < 12) ? depth_reg : 12;
        need = TOKEN_BITS'($urandom_range(0, cap));
        if (pick < 45) begin
            send_event(KIND_TICK, TOKEN_BITS'($urandom_range(0, 1023)));
        end else if (pick < 88) begin
            send_event(KIND_ARRIVAL, need);
        end else if (pick < 95) begin
            if (depth_reg < 10'd1023)
                need = TOKEN_BITS'($urandom_range(depth_reg + 1, 1023));
            send_event(KIND_ARRIVAL, need);
        end else begin
            send_event(KIND_UNUSED, TOKEN_BITS'($urandom_range(0, 1023)));
        end
    endtask

    task automatic test_directed();
        int i;
        send_event(KIND_TICK, 10'd0);
        send_event(KIND_ARRIVAL, 10'd0);
        send_event(KIND_ARRIVAL, 10'd1023);
        send_event(KIND_ARRIVAL, 10'd10);
        send_event(KIND_UNUSED, 10'd1023);
        for (i = 0; i < 9; i++) send_event(KIND_TICK, 10'd0);
        for (i = 0; i < 11; i++) send_event(KIND_TICK, 10'd1023);
        send_event(KIND_ARRIVAL, 10'd11);
        send_event(KIND_ARRIVAL, 10'd10);
        wait_idle();
    endtask

    // depth 0, then 1023: head needs one token more than the level, a smaller packet waits behind it
    task automatic test_depth_extremes();
        write_depth(10'd0);
        send_event(KIND_TICK, 10'd0);
        send_event(KIND_ARRIVAL, 10'd0);
        send_event(KIND_ARRIVAL, 10'd1);
        send_event(KIND_ARRIVAL, 10'd1023);
        write_depth(10'd1023);
        send_event(KIND_TICK, 10'd0);
        send_event(KIND_TICK, 10'd0);
        send_event(KIND_ARRIVAL, 10'd3);
        send_event(KIND_ARRIVAL, 10'd2);
        wait_idle();
    endtask

    // lowering the depth under the level keeps the tokens, ticks count as dropped
    task automatic test_depth_below_level();
        int i;
        write_depth(10'd1023);
        for (i = 0; i < 12; i++) send_event(KIND_TICK, 10'd0);
        write_depth(10'd3);
        send_event(KIND_TICK, 10'd0);
        send_event(KIND_ARRIVAL, 10'd5);
        send_event(KIND_ARRIVAL, 10'd2);
        send_event(KIND_ARRIVAL, 10'd3);
        send_event(KIND_TICK, 10'd0);
        wait_idle();
    endtask

    // head blocked by one packet just over the level, the rest pile up behind it
    task automatic test_queue_full();
        int i;
        write_depth(10'd1023);
        send_event(KIND_ARRIVAL, bucket_level + TOKEN_BITS'(1));
        for (i = 0; i < 70; i++) send_event(KIND_ARRIVAL, TOKEN_BITS'($urandom_range(0, 2)));
        while (waiting != 0) send_event(KIND_TICK, TOKEN_BITS'($urandom_range(0, 1023)));
        wait_idle();
    endtask

    task automatic test_backpressure();
        int i;
        idle_on  = 1'b0;
        hold_len = 250;
        hold_req = 1'b1;
        for (i = 0; i < 30; i++) send_random_event();
        wait_idle();
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic(input logic [TOKEN_BITS-1:0] depth, input int count,
                                       input bit with_idle);
        int i;
        write_depth(depth);
        idle_on = with_idle;
        for (i = 0; i < count; i++) send_random_event();
        wait_idle();
    endtask

    // a flush halts the gate for good, so it runs last
    task automatic test_flush_halt();
        int i;
        for (i = 0; i < 5; i++) send_event(KIND_ARRIVAL, depth_reg);
        send_event(KIND_FLUSH, 10'd0);
        send_event(KIND_TICK, 10'd0);
        send_event(KIND_ARRIVAL, 10'd3);
        send_event(KIND_FLUSH, 10'd1023);
        send_event(KIND_UNUSED, 10'd0);
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_depth_extremes();
        test_depth_below_level();
        test_queue_full();
        test_backpressure();
        test_random_traffic(10'd1023, 45, 1'b1);
        test_random_traffic(TOKEN_BITS'($urandom_range(2, 1022)), 45, 1'b0);
        test_random_traffic(10'd1, 40, 1'b1);
        test_random_traffic(10'd0, 20, 1'b1);
        test_random_traffic(TOKEN_BITS'($urandom_range(13, 60)), 35, 1'b1);
        test_random_traffic(10'd10, 40, 1'b0);
        test_flush_halt();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
design/tbpg_pkg.sv
design/tbpg_queue.sv
design/token_bucket_packet_gate_unit.sv
verif/tb_top.sv
